FILE: rtl/core/isd_pkg.sv
`timescale 1ns / 1ps
// isd_pkg: shared types and constants for the descending insertion sorter
// used by isd_cell and insertion_sorter_descending_unit; no dependencies

package isd_pkg;

    // width of one sorted value
    localparam int DATA_W = 32;

    // default number of cells in the chain
    localparam int CAPACITY_DEF = 32;

    // what one cell shows its neighbours
    typedef struct packed {
        logic              valid;
        logic              move;
        logic [DATA_W-1:0] value;
    } link_t;

    // chain-wide operation for this cycle
    typedef struct packed {
        logic insert;
        logic drain;
    } ctrl_t;

endpackage

FILE: rtl/core/isd_cell.sv
`timescale 1ns / 1ps
// isd_cell: one compare-and-shift cell of the sorting chain
// depends on isd_pkg for link_t and ctrl_t

module isd_cell
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  isd_pkg::ctrl_t                    ctrl,
    input  logic signed [isd_pkg::DATA_W-1:0] sample,
    input  isd_pkg::link_t                    prev_link,
    input  isd_pkg::link_t                    next_link,
    output isd_pkg::link_t                    link
);

    logic                      valid_reg;
    logic                      valid_next;
    logic [isd_pkg::DATA_W-1:0] value_reg;
    logic [isd_pkg::DATA_W-1:0] value_next;
    logic                      move;

    // cell is empty or holds a value strictly below the new one
    assign move = !valid_reg || ($signed(value_reg) < sample);

    assign link.valid = valid_reg;
    assign link.move  = move;
    assign link.value = value_reg;

    // next content: insert shifts towards the tail, drain towards the head
    always_comb
    begin
        valid_next = valid_reg;
        value_next = value_reg;
        if (ctrl.drain)
        begin
            valid_next = next_link.valid;
            value_next = next_link.value;
        end
        else if (ctrl.insert && move)
        begin
            if (!prev_link.move)
            begin
                valid_next = 1'b1;
                value_next = sample;
            end
            else if (prev_link.valid)
            begin
                valid_next = 1'b1;
                value_next = prev_link.value;
            end
        end
    end

    // occupancy flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // stored value, no reset needed
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

FILE: rtl/core/insertion_sorter_descending_unit.sv
`timescale 1ns / 1ps
// insertion_sorter_descending_unit: top level, chain of isd_cell instances
// plus fill count, overflow flag and drain control; depends on isd_pkg
// Throughput: one input item per cycle while a set is being filled.
// Latency: the first sorted item is offered the cycle after the closing item.
// Drain: one sorted item per cycle from the head cell while out_ready is high; input held off until done.
// Reset: asynchronous, clears cell occupancy, fill count, overflow and drain state.

module insertion_sorter_descending_unit
#(
    parameter int CAPACITY = isd_pkg::CAPACITY_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [isd_pkg::DATA_W-1:0] sample_value,
    input  logic                              end_of_set,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [isd_pkg::DATA_W-1:0] sorted_value,
    output logic                              final_result,
    output logic                              overflowed
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    isd_pkg::link_t links [CAPACITY];
    isd_pkg::link_t head_prev;
    isd_pkg::link_t tail_next;
    isd_pkg::ctrl_t ctrl;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             overflow_reg;
    logic             overflow_next;
    logic             drain_reg;
    logic             drain_next;
    logic             in_acc;
    logic             out_acc;
    logic             full;
    logic             last_out;

    // handshakes
    assign in_ready = !drain_reg;
    assign in_acc   = in_valid && in_ready;
    assign out_valid = drain_reg;
    assign out_acc  = out_valid && out_ready;

    assign full     = (count_reg == CNT_W'(CAPACITY));
    assign last_out = (count_reg == CNT_W'(1));

    assign ctrl.insert = in_acc && !full;
    assign ctrl.drain  = out_acc;

    // chain ends: head takes the new value first, tail fills with empty
    assign head_prev.valid = 1'b1;
    assign head_prev.move  = 1'b0;
    assign head_prev.value = '0;
    assign tail_next.valid = 1'b0;
    assign tail_next.move  = 1'b0;
    assign tail_next.value = '0;

    // row of cells
    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            isd_cell u_cell
            (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (ctrl),
                .sample    (sample_value),
                .prev_link ((i == 0) ? head_prev : links[(i == 0) ? 0 : i - 1]),
                .next_link ((i == CAPACITY - 1) ? tail_next
                                                : links[(i == CAPACITY - 1) ? i : i + 1]),
                .link      (links[i])
            );
        end
    endgenerate

    // sorted value comes straight from the head cell, the flags from fill count and overflow state
    assign sorted_value = $signed(links[0].value);
    assign final_result = last_out;
    assign overflowed   = overflow_reg;

    // fill count, overflow and drain control
    always_comb
    begin
        count_next    = count_reg;
        overflow_next = overflow_reg;
        drain_next    = drain_reg;
        if (in_acc)
        begin
            if (full)
                overflow_next = 1'b1;
            else
                count_next = count_reg + CNT_W'(1);
            if (end_of_set)
                drain_next = 1'b1;
        end
        if (out_acc)
        begin
            count_next = count_reg - CNT_W'(1);
            if (last_out)
            begin
                drain_next    = 1'b0;
                overflow_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            overflow_reg <= 1'b0;
            drain_reg    <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            overflow_reg <= overflow_next;
            drain_reg    <= drain_next;
        end
    end

    // fill count never exceeds the chain length
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("fill count above capacity");

    // head cell occupancy tracks a non-zero fill count
    a_head_valid: assert property (@(posedge clk) disable iff (!rst_n)
        links[0].valid == (count_reg != '0))
        else $error("head cell occupancy disagrees with fill count");

    // the chain is full exactly when the tail cell is occupied
    a_tail_valid: assert property (@(posedge clk) disable iff (!rst_n)
        links[CAPACITY-1].valid == full)
        else $error("tail cell occupancy disagrees with fill count");

    // a drain always has something to emit
    a_drain_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        drain_reg |-> (count_reg != '0))
        else $error("drain with empty chain");

    // after the final item is taken the chain is empty, overflow is clear and input reopens
    a_drain_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_acc && last_out) |=> (count_reg == '0) && in_ready && !overflow_reg)
        else $error("set not closed after final item");

endmodule

FILE: sim/isd_sort_checker.sv
`timescale 1ns / 1ps
// isd_sort_checker: watches both item channels of the descending insertion
// sorter, predicts each sorted item and compares it; depends on isd_pkg

module isd_sort_checker
#(
    parameter int CAPACITY = isd_pkg::CAPACITY_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic                              in_ready,
    input  logic signed [isd_pkg::DATA_W-1:0] sample_value,
    input  logic                              end_of_set,
    input  logic                              out_valid,
    input  logic                              out_ready,
    input  logic signed [isd_pkg::DATA_W-1:0] sorted_value,
    input  logic                              final_result,
    input  logic                              overflowed,
    output int                                mismatch_count,
    output int                                pending_results
);

    // one predicted sorted item
    typedef struct {
        logic signed [isd_pkg::DATA_W-1:0] value;
        logic                              closing;
        logic                              dropped;
    } sorted_item_t;

    // predicted store, kept in descending order
    logic signed [isd_pkg::DATA_W-1:0] ranked_values [CAPACITY];
    logic [$clog2(CAPACITY+1)-1:0]     ranked_count;
    logic                              dropped_flag;
    sorted_item_t                      expected_sorted [$];

    // print one line per mismatch and count it
    task automatic flag_mismatch(input string what);
        $display("[%0t] sorter check: %s", $realtime, what);
        mismatch_count++;
    endtask

    // place a value behind every stored value that is greater or equal
    task automatic rank_sample(input logic signed [isd_pkg::DATA_W-1:0] v);
        int pos;
        int k;
        if (ranked_count == CAPACITY) begin
            dropped_flag = 1'b1;
        end
        else begin
            pos = ranked_count;
            while (pos > 0 && ranked_values[pos-1] < v)
                pos--;
            for (k = ranked_count; k > pos; k--)
                ranked_values[k] = ranked_values[k-1];
            ranked_values[pos] = v;
            ranked_count++;
        end
    endtask

    // emit the whole store largest first, then empty it
    task automatic close_set();
        sorted_item_t item;
        int k;
        for (k = 0; k < ranked_count; k++)
        begin
            item.value   = ranked_values[k];
            item.closing = (k + 1 == ranked_count);
            item.dropped = dropped_flag;
            expected_sorted.push_back(item);
        end
        ranked_count = '0;
        dropped_flag = 1'b0;
    endtask

    // input side first, then the sorted item side
    always @(posedge clk or negedge rst_n)
    begin
        sorted_item_t want;
        if (!rst_n)
        begin
            ranked_count   = '0;
            dropped_flag   = 1'b0;
            mismatch_count = 0;
            expected_sorted.delete();
            pending_results <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                rank_sample(sample_value);
                if (end_of_set)
                    close_set();
            end
            if (out_valid && out_ready)
            begin
                if (expected_sorted.size() == 0)
                begin
                    flag_mismatch($sformatf("unexpected item value %0d", sorted_value));
                end
                else
                begin
                    want = expected_sorted.pop_front();
                    if (sorted_value !== want.value)
                        flag_mismatch($sformatf("sorted_value %0d, predicted %0d",
                                                sorted_value, want.value));
                    if (final_result !== want.closing)
                        flag_mismatch($sformatf("final_result %b, predicted %b",
                                                final_result, want.closing));
                    if (overflowed !== want.dropped)
                        flag_mismatch($sformatf("overflowed %b, predicted %b",
                                                overflowed, want.dropped));
                end
            end
            pending_results <= expected_sorted.size();
        end
    end

endmodule

FILE: sim/tb_insertion_sorter_descending_unit.sv
`timescale 1ns / 1ps
// tb_insertion_sorter_descending_unit: stimulus and verdict for the sorter
// depends on isd_pkg, insertion_sorter_descending_unit and isd_sort_checker

module tb_insertion_sorter_descending_unit;

    localparam int CAPACITY     = isd_pkg::CAPACITY_DEF;
    localparam int RANDOM_ITEMS = 260;
    localparam int HOLD_CYCLES  = 120;

    logic                              clk;
    logic                              rst_n;
    logic                              in_valid;
    logic                              in_ready;
    logic signed [isd_pkg::DATA_W-1:0] sample_value;
    logic                              end_of_set;
    logic                              out_valid;
    logic                              out_ready;
    logic signed [isd_pkg::DATA_W-1:0] sorted_value;
    logic                              final_result;
    logic                              overflowed;

    int mismatch_count;
    int pending_results;
    int samples_sent;
    bit sender_calm;
    bit receiver_calm;
    bit hold_request;

    insertion_sorter_descending_unit #(.CAPACITY(CAPACITY)) dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .sample_value (sample_value),
        .end_of_set   (end_of_set),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .sorted_value (sorted_value),
        .final_result (final_result),
        .overflowed   (overflowed)
    );

    isd_sort_checker #(.CAPACITY(CAPACITY)) u_checker
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .sample_value    (sample_value),
        .end_of_set      (end_of_set),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .sorted_value    (sorted_value),
        .final_result    (final_result),
        .overflowed      (overflowed),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // run limit
    initial
    begin
        #5_000_000;
        $display("insertion_sorter_descending_unit: mismatch");
        $finish;
    end

    // offer one item, after a random gap, and wait until it is taken
    task automatic offer_sample(input logic signed [isd_pkg::DATA_W-1:0] v,
                                input logic eos);
        int gap;
        gap = sender_calm ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        sample_value <= v;
        end_of_set   <= eos;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        samples_sent++;
    endtask

    // wait until every predicted sorted item has come out
    task automatic await_sorted();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // mix of extremes, near ties and full-range values
    function automatic logic signed [isd_pkg::DATA_W-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2, 3:    return $signed($urandom_range(0, 6)) - 3;
            default: return $signed($urandom);
        endcase
    endfunction

    // random set size, mostly short, sometimes full or past capacity
    function automatic int pick_set_size();
        int r;
        r = $urandom_range(0, 15);
        if (r == 0)
            return CAPACITY + $urandom_range(1, 4);
        else if (r == 1)
            return CAPACITY;
        else if (r < 6)
            return $urandom_range(2, CAPACITY - 1);
        else
            return $urandom_range(1, 8);
    endfunction

    // receiver: random stalls, calm stretches and one long hold-off
    initial
    begin
        int stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_request)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
                out_ready <= 1'b1;
            end
            else
            begin
                stall = receiver_calm ? 0 : $urandom_range(0, 15);
                if (stall > 0)
                begin
                    out_ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
                out_ready <= 1'b1;
            end
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            if ($urandom_range(0, 31) == 0)
                receiver_calm = ~receiver_calm;
        end
    end

    // stimulus and verdict
    initial
    begin
        int size;
        int k;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        sample_value  = '0;
        end_of_set    = 1'b0;
        samples_sent  = 0;
        sender_calm   = 1'b0;
        receiver_calm = 1'b0;
        hold_request  = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // single-item sets at both extremes
        offer_sample(32'sh7FFF_FFFF, 1'b1);
        offer_sample(32'sh8000_0000, 1'b1);

        // extremes, signs and ties that must keep arrival order
        offer_sample(0, 1'b0);
        offer_sample(-1, 1'b0);
        offer_sample(1, 1'b0);
        offer_sample(32'sh8000_0000, 1'b0);
        offer_sample(32'sh7FFF_FFFF, 1'b0);
        offer_sample(-1, 1'b0);
        offer_sample(1, 1'b0);
        offer_sample(32'sh7FFF_FFFF, 1'b0);
        offer_sample(32'sh8000_0000, 1'b0);
        offer_sample(0, 1'b1);

        // already descending, then ascending
        sender_calm = 1'b1;
        for (k = 3; k >= -2; k--)
            offer_sample(k, k == -2);
        for (k = -2; k <= 3; k++)
            offer_sample(k, k == 3);
        sender_calm = 1'b0;
        await_sorted();

        // store full and closing item dropped, read side held off meanwhile
        hold_request = 1'b1;
        sender_calm  = 1'b1;
        for (k = 0; k < CAPACITY + 3; k++)
            offer_sample(pick_sample(), k == CAPACITY + 2);
        offer_sample(pick_sample(), 1'b0);
        offer_sample(pick_sample(), 1'b1);
        sender_calm = 1'b0;

        // random sets until the item budget is used
        while (samples_sent < RANDOM_ITEMS)
        begin
            sender_calm = ($urandom_range(0, 3) == 0);
            size = pick_set_size();
            for (k = 0; k < size; k++)
                offer_sample(pick_sample(), k == size - 1);
            if ($urandom_range(0, 7) == 0)
                await_sorted();
        end

        await_sorted();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && pending_results == 0)
            $display("insertion_sorter_descending_unit: match");
        else
            $display("insertion_sorter_descending_unit: mismatch");
        $finish;
    end

endmodule
